FILE: rtl/emp_pkg.sv
// ----------------------------------------------------------------------------
// emp_pkg: shared types and constants of the eased move profile generator
// Command and result bundles of the shared shift-add/subtract unit, register
// indexes of the configuration port and fixed-point constants.
// ----------------------------------------------------------------------------
package emp_pkg;

   localparam int OPND_W = 33;   // multiplicand / divisor
   localparam int SH_W   = 49;   // multiplier bits / dividend-quotient shifter
   localparam int ACC_W  = 57;   // product / remainder
   localparam int REM_W  = 26;   // remainder part of the accumulator
   localparam int CNT_W  = 6;

   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic              start;
      mdu_op_type        op;
      logic [CNT_W-1:0]  count;
      logic [OPND_W-1:0] opnd;
      logic [SH_W-1:0]   sh_init;
      logic [REM_W-1:0]  rem_init;
   } mdu_cmd_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] acc;
      logic [SH_W-1:0]  sh;
   } mdu_rsp_type;

   // configuration register indexes
   localparam logic [2:0] CSR_OFFSET_X      = 3'd0;
   localparam logic [2:0] CSR_OFFSET_Y      = 3'd1;
   localparam logic [2:0] CSR_OFFSET_Z      = 3'd2;
   localparam logic [2:0] CSR_MOVE_TIME     = 3'd3;
   localparam logic [2:0] CSR_EASE_IN_TIME  = 3'd4;
   localparam logic [2:0] CSR_EASE_OUT_TIME = 3'd5;

   // iteration counts, one bit per cycle
   localparam logic [CNT_W-1:0] CNT_TIME_MUL  = 6'd24;
   localparam logic [CNT_W-1:0] CNT_RAMP_DIV  = 6'd24;
   localparam logic [CNT_W-1:0] CNT_VEL_DIV   = 6'd49;
   localparam logic [CNT_W-1:0] CNT_RATIO_DIV = 6'd16;
   localparam logic [CNT_W-1:0] CNT_SQUARE    = 6'd16;
   localparam logic [CNT_W-1:0] CNT_CUBE      = 6'd18;
   localparam logic [CNT_W-1:0] CNT_STEP_FAC  = 6'd17;
   localparam logic [CNT_W-1:0] CNT_STEP_DT   = 6'd16;

   localparam logic [24:0] ELAPSED_MAX = 25'h1FFFFFF;
   localparam logic [16:0] ONE_Q16     = 17'h10000;
   localparam logic [17:0] THREE_Q16   = 18'h30000;

endpackage

FILE: rtl/emp_mdu.sv
// ----------------------------------------------------------------------------
// emp_mdu: shared shift-add/subtract unit
// Radix-2 multiply (multiplier scanned from its msb) or restoring divide, one
// bit per cycle through a single adder. The operands arrive pre-aligned.
// ----------------------------------------------------------------------------
module emp_mdu (
   input  logic                clock,
   input  logic                reset,
   input  emp_pkg::mdu_cmd_type cmd,
   output emp_pkg::mdu_rsp_type rsp
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [emp_pkg::CNT_W-1:0]   cnt_ff;
   emp_pkg::mdu_op_type         op_ff;
   logic [emp_pkg::OPND_W-1:0]  opnd_ff;
   logic [emp_pkg::ACC_W-1:0]   acc_ff;
   logic [emp_pkg::SH_W-1:0]    sh_ff;

   logic                        is_div;
   logic [emp_pkg::ACC_W-1:0]   add_x;
   logic [emp_pkg::OPND_W-1:0]  add_y;
   logic [emp_pkg::ACC_W:0]     add_sum;
   logic                        fits;
   logic [emp_pkg::ACC_W-1:0]   acc_in;
   logic [emp_pkg::SH_W-1:0]    sh_in;

   always_comb begin
      is_div = (op_ff == emp_pkg::MDU_DIV);
      if (is_div) begin
         // shift the next dividend bit into the remainder
         add_x = {{(emp_pkg::ACC_W-emp_pkg::REM_W-1){1'b0}},
                  acc_ff[emp_pkg::REM_W-1:0], sh_ff[emp_pkg::SH_W-1]};
         add_y = opnd_ff;
      end else begin
         add_x = {acc_ff[emp_pkg::ACC_W-2:0], 1'b0};
         add_y = sh_ff[emp_pkg::SH_W-1] ? opnd_ff : '0;
      end
      add_sum = {1'b0, add_x}
              + ({{(emp_pkg::ACC_W-emp_pkg::OPND_W+1){1'b0}}, add_y}
                 ^ {(emp_pkg::ACC_W+1){is_div}})
              + {{emp_pkg::ACC_W{1'b0}}, is_div};
      fits = !add_sum[emp_pkg::ACC_W];
      if (is_div) begin
         acc_in = fits ? add_sum[emp_pkg::ACC_W-1:0] : add_x;
         sh_in  = {sh_ff[emp_pkg::SH_W-2:0], fits};
      end else begin
         acc_in = add_sum[emp_pkg::ACC_W-1:0];
         sh_in  = {sh_ff[emp_pkg::SH_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.count;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= cmd.op;
         opnd_ff <= cmd.opnd;
         sh_ff   <= cmd.sh_init;
         acc_ff  <= (cmd.op == emp_pkg::MDU_DIV)
                    ? {{(emp_pkg::ACC_W-emp_pkg::REM_W){1'b0}}, cmd.rem_init} : '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         sh_ff  <= sh_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.acc  = acc_ff;
   assign rsp.sh   = sh_ff;

endmodule

FILE: rtl/eased_move_profile_generator.sv
// ----------------------------------------------------------------------------
// eased_move_profile_generator: relative 3-D move with smoothstep ramps
// A restart item goes straight from idle to output. A running tick steps each
// axis, with ease terms inside a ramp and ramp/velocity setup after a restart.
// Throughput: one item at a time, the next is taken once the result is queued.
// Rate set by the one shared shift-add/subtract unit, one bit per cycle.
// Reset clears all motion state and configuration registers to zero.
// ----------------------------------------------------------------------------
module eased_move_profile_generator (
   input  logic         clock,
   input  logic         reset,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   // tick items in
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // delta_time[15:0], start_x, start_y, start_z
   input  logic         req_tuser,   // restart
   // position items out
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // pos_x[31:0], pos_y, pos_z
   output logic         rsp_tuser    // done_res
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RAMP,
      ST_RIN_MUL,
      ST_RIN_DIV,
      ST_ROUT_MUL,
      ST_ROUT_DIV,
      ST_DENOM,
      ST_VEL,
      ST_VEL_DIV,
      ST_FACTOR,
      ST_RATIO_DIV,
      ST_SQUARE,
      ST_CUBE,
      ST_STEP,
      ST_STEP_FAC,
      ST_STEP_DT,
      ST_ELAPSED,
      ST_OUT
   } state_type;

   state_type            state_ff;
   emp_pkg::mdu_cmd_type mdu_cmd_ff;
   emp_pkg::mdu_rsp_type mdu_rsp;

   // configuration
   logic [31:0] offset_ff [3];
   logic [23:0] move_time_ff;
   logic [23:0] ease_in_ff;
   logic [23:0] ease_out_ff;

   // motion state
   logic [24:0] elapsed_ff;
   logic        started_ff;
   logic [31:0] vel_ff [3];
   logic [31:0] pos_ff [3];
   logic [23:0] rin_ff;
   logic [23:0] rout_ff;

   // per-item working registers
   logic [1:0]  axis_ff;
   logic [15:0] dt_ff;
   logic [24:0] denom_ff;
   logic [15:0] ratio_ff;
   logic [16:0] factor_ff;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   logic [24:0] ramp_sum;
   logic        rescale;
   logic [25:0] denom_calc;
   logic [31:0] off_sel;
   logic        off_neg;
   logic [31:0] off_mag;
   logic [31:0] vel_sel;
   logic        vel_neg;
   logic [31:0] vel_mag;
   logic        pos_sat;
   logic        neg_sat;
   logic [31:0] vel_new;
   logic        in_ramp_in;
   logic        in_ramp_out;
   logic        e_ge_t;
   logic [23:0] t_minus_e;
   logic [17:0] cube_k;
   logic [31:0] step_mag;
   logic [31:0] step_val;
   logic [25:0] el_sum;
   logic [24:0] el_next;
   logic        axis_last;

   function automatic emp_pkg::mdu_cmd_type mdu_issue(
      input emp_pkg::mdu_op_type        op,
      input logic [emp_pkg::CNT_W-1:0]  count,
      input logic [emp_pkg::OPND_W-1:0] opnd,
      input logic [emp_pkg::SH_W-1:0]   sh_init,
      input logic [emp_pkg::REM_W-1:0]  rem_init
   );
      emp_pkg::mdu_cmd_type c;
      c.start    = 1'b1;
      c.op       = op;
      c.count    = count;
      c.opnd     = opnd;
      c.sh_init  = sh_init;
      c.rem_init = rem_init;
      return c;
   endfunction

   emp_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd_ff),
      .rsp   (mdu_rsp)
   );

   always_comb begin
      ramp_sum   = {1'b0, ease_in_ff} + {1'b0, ease_out_ff};
      rescale    = ramp_sum > {1'b0, move_time_ff};
      denom_calc = {1'b0, move_time_ff, 1'b0} - {2'b0, rin_ff} - {2'b0, rout_ff};

      off_sel = offset_ff[axis_ff];
      off_neg = off_sel[31];
      off_mag = off_neg ? (32'd0 - off_sel) : off_sel;
      vel_sel = vel_ff[axis_ff];
      vel_neg = vel_sel[31];
      vel_mag = vel_neg ? (32'd0 - vel_sel) : vel_sel;

      // quotient saturation to the signed 32-bit range
      pos_sat = |mdu_rsp.sh[48:31];
      neg_sat = (|mdu_rsp.sh[48:32]) || (mdu_rsp.sh[31] && (|mdu_rsp.sh[30:0]));
      if (!off_neg)
         vel_new = pos_sat ? 32'h7FFFFFFF : mdu_rsp.sh[31:0];
      else
         vel_new = neg_sat ? 32'h80000000 : (32'd0 - mdu_rsp.sh[31:0]);

      in_ramp_in  = elapsed_ff < {1'b0, rin_ff};
      in_ramp_out = ({1'b0, elapsed_ff} + {2'b0, rout_ff}) > {2'b0, move_time_ff};
      e_ge_t      = elapsed_ff >= {1'b0, move_time_ff};
      t_minus_e   = move_time_ff - elapsed_ff[23:0];
      cube_k      = emp_pkg::THREE_Q16 - {1'b0, ratio_ff, 1'b0};

      step_mag = mdu_rsp.acc[47:16];
      step_val = vel_neg ? (32'd0 - step_mag) : step_mag;

      el_sum  = {1'b0, elapsed_ff} + {10'b0, dt_ff};
      el_next = el_sum[25] ? emp_pkg::ELAPSED_MAX : el_sum[24:0];

      axis_last = (axis_ff == 2'd2);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
         move_time_ff <= '0;
         ease_in_ff   <= '0;
         ease_out_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            emp_pkg::CSR_OFFSET_X:      offset_ff[0] <= csr_data;
            emp_pkg::CSR_OFFSET_Y:      offset_ff[1] <= csr_data;
            emp_pkg::CSR_OFFSET_Z:      offset_ff[2] <= csr_data;
            emp_pkg::CSR_MOVE_TIME:     move_time_ff <= csr_data[23:0];
            emp_pkg::CSR_EASE_IN_TIME:  ease_in_ff   <= csr_data[23:0];
            emp_pkg::CSR_EASE_OUT_TIME: ease_out_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mdu_cmd_ff    <= '0;
         axis_ff       <= '0;
         elapsed_ff    <= '0;
         started_ff    <= 1'b0;
         vel_ff[0]     <= '0;
         vel_ff[1]     <= '0;
         vel_ff[2]     <= '0;
         pos_ff[0]     <= '0;
         pos_ff[1]     <= '0;
         pos_ff[2]     <= '0;
         rin_ff        <= '0;
         rout_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         mdu_cmd_ff.start <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready)
            rsp_tvalid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  dt_ff <= req_tdata[15:0];
                  if (req_tuser) begin
                     elapsed_ff <= '0;
                     started_ff <= 1'b0;
                     state_ff   <= ST_OUT;
                  end else if (!started_ff) begin
                     pos_ff[0] <= req_tdata[47:16];
                     pos_ff[1] <= req_tdata[79:48];
                     pos_ff[2] <= req_tdata[111:80];
                     state_ff  <= ST_RAMP;
                  end else begin
                     state_ff <= ST_FACTOR;
                  end
               end
            end

            ST_RAMP: begin
               if (rescale) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_TIME_MUL,
                                          {9'b0, move_time_ff}, {ease_in_ff, 25'b0}, '0);
                  state_ff   <= ST_RIN_MUL;
               end else begin
                  rin_ff   <= ease_in_ff;
                  rout_ff  <= ease_out_ff;
                  state_ff <= ST_DENOM;
               end
            end

            ST_RIN_MUL: begin
               if (mdu_rsp.done) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_DIV, emp_pkg::CNT_RAMP_DIV,
                                          {8'b0, ramp_sum}, {mdu_rsp.acc[23:0], 25'b0},
                                          {2'b0, mdu_rsp.acc[47:24]});
                  state_ff   <= ST_RIN_DIV;
               end
            end

            ST_RIN_DIV: begin
               if (mdu_rsp.done) begin
                  rin_ff     <= mdu_rsp.sh[23:0];
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_TIME_MUL,
                                          {9'b0, move_time_ff}, {ease_out_ff, 25'b0}, '0);
                  state_ff   <= ST_ROUT_MUL;
               end
            end

            ST_ROUT_MUL: begin
               if (mdu_rsp.done) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_DIV, emp_pkg::CNT_RAMP_DIV,
                                          {8'b0, ramp_sum}, {mdu_rsp.acc[23:0], 25'b0},
                                          {2'b0, mdu_rsp.acc[47:24]});
                  state_ff   <= ST_ROUT_DIV;
               end
            end

            ST_ROUT_DIV: begin
               if (mdu_rsp.done) begin
                  rout_ff  <= mdu_rsp.sh[23:0];
                  state_ff <= ST_DENOM;
               end
            end

            ST_DENOM: begin
               // never negative: the effective ramps sum to at most the move time
               denom_ff <= denom_calc[24:0];
               axis_ff  <= '0;
               state_ff <= ST_VEL;
            end

            ST_VEL: begin
               if (denom_ff == '0) begin
                  vel_ff[axis_ff] <= '0;
                  if (axis_last) begin
                     started_ff <= 1'b1;
                     state_ff   <= ST_FACTOR;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                  end
               end else begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_DIV, emp_pkg::CNT_VEL_DIV,
                                          {8'b0, denom_ff}, {off_mag, 17'b0}, '0);
                  state_ff   <= ST_VEL_DIV;
               end
            end

            ST_VEL_DIV: begin
               if (mdu_rsp.done) begin
                  vel_ff[axis_ff] <= vel_new;
                  if (axis_last) begin
                     started_ff <= 1'b1;
                     state_ff   <= ST_FACTOR;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_VEL;
                  end
               end
            end

            ST_FACTOR: begin
               axis_ff <= '0;
               if (in_ramp_in) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_DIV, emp_pkg::CNT_RATIO_DIV,
                                          {9'b0, rin_ff}, '0, {1'b0, elapsed_ff});
                  state_ff   <= ST_RATIO_DIV;
               end else if (in_ramp_out) begin
                  if (e_ge_t || (rout_ff == '0)) begin
                     // ease factor is zero: position holds
                     state_ff <= ST_ELAPSED;
                  end else begin
                     mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_DIV, emp_pkg::CNT_RATIO_DIV,
                                             {9'b0, rout_ff}, '0, {2'b0, t_minus_e});
                     state_ff   <= ST_RATIO_DIV;
                  end
               end else begin
                  factor_ff <= emp_pkg::ONE_Q16;
                  state_ff  <= ST_STEP;
               end
            end

            ST_RATIO_DIV: begin
               // ratio is strictly below one here
               if (mdu_rsp.done) begin
                  ratio_ff   <= mdu_rsp.sh[15:0];
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_SQUARE,
                                          {17'b0, mdu_rsp.sh[15:0]},
                                          {mdu_rsp.sh[15:0], 33'b0}, '0);
                  state_ff   <= ST_SQUARE;
               end
            end

            ST_SQUARE: begin
               if (mdu_rsp.done) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_CUBE,
                                          {1'b0, mdu_rsp.acc[31:0]}, {cube_k, 31'b0}, '0);
                  state_ff   <= ST_CUBE;
               end
            end

            ST_CUBE: begin
               if (mdu_rsp.done) begin
                  factor_ff <= mdu_rsp.acc[48:32];
                  state_ff  <= ST_STEP;
               end
            end

            ST_STEP: begin
               mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_STEP_FAC,
                                       {1'b0, vel_mag}, {factor_ff, 32'b0}, '0);
               state_ff   <= ST_STEP_FAC;
            end

            ST_STEP_FAC: begin
               if (mdu_rsp.done) begin
                  mdu_cmd_ff <= mdu_issue(emp_pkg::MDU_MUL, emp_pkg::CNT_STEP_DT,
                                          mdu_rsp.acc[48:16], {dt_ff, 33'b0}, '0);
                  state_ff   <= ST_STEP_DT;
               end
            end

            ST_STEP_DT: begin
               if (mdu_rsp.done) begin
                  pos_ff[axis_ff] <= pos_ff[axis_ff] + step_val;
                  if (axis_last) begin
                     state_ff <= ST_ELAPSED;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_STEP;
                  end
               end
            end

            ST_ELAPSED: begin
               elapsed_ff <= el_next;
               state_ff   <= ST_OUT;
            end

            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {pos_ff[2], pos_ff[1], pos_ff[0]};
                  rsp_tuser_ff  <= started_ff && e_ge_t;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
